FILE: design/afc_pkg.sv
`timescale 1ns / 1ps
package afc_pkg;

	localparam int MAT_DEPTH     = 16;
	localparam int MAT_IDX_W     = 4;
	localparam int VAL_W         = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QUEUE_PTR_W   = 2;
	localparam int IN_DATA_W     = 232;
	localparam int OUT_DATA_W    = 8;
	localparam int VERDICT_W     = 2;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TEST = 1'b1
	} op_t;

	typedef enum logic [VERDICT_W-1:0] {
		V_INSIDE  = 2'd0,
		V_PARTIAL = 2'd1,
		V_OUTSIDE = 2'd2
	} verdict_t;

	typedef struct packed {
		op_t                   op;
		logic [MAT_IDX_W-1:0]  entry_index;
		logic [VAL_W-1:0]      entry_value;
		logic [2:0][VAL_W-1:0] center;
		logic [2:0][VAL_W-1:0] extent;
	} item_t;

endpackage

FILE: design/afc_front.sv
`timescale 1ns / 1ps
module afc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [afc_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           s_tuser,
	output logic                           push_valid,
	input  logic                           push_ready,
	output afc_pkg::item_t                 push_item
);
	import afc_pkg::*;

	logic  valid_q;
	item_t item_q;
	item_t item_d;

	// unpack the transaction and decode its kind
	always_comb begin
		item_d.op          = op_t'(s_tuser);
		item_d.entry_index = s_tdata[3:0];
		item_d.entry_value = s_tdata[35:4];
		item_d.center[0]   = s_tdata[67:36];
		item_d.center[1]   = s_tdata[99:68];
		item_d.center[2]   = s_tdata[131:100];
		item_d.extent[0]   = s_tdata[163:132];
		item_d.extent[1]   = s_tdata[195:164];
		item_d.extent[2]   = s_tdata[227:196];
	end

	assign s_tready   = !valid_q || push_ready;
	assign push_valid = valid_q;
	assign push_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_q <= item_d;
		end
	end
endmodule

FILE: design/afc_queue.sv
`timescale 1ns / 1ps
module afc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  afc_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop_ready,
	output afc_pkg::item_t pop_item
);
	import afc_pkg::*;

	item_t                  mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;
	logic                   do_push;
	logic                   do_pop;

	assign push_ready = count_q != (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end
endmodule

FILE: design/afc_back.sv
`timescale 1ns / 1ps
module afc_back #(
	parameter int FRAC_BITS = afc_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  afc_pkg::item_t                pop_item,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [afc_pkg::OUT_DATA_W-1:0] m_tdata
);
	import afc_pkg::*;

	localparam int WS_W  = 33 + FRAC_BITS;
	localparam int BIG_W = (WS_W > 68) ? WS_W : 68;
	localparam int SUM_W = BIG_W + 2;

	logic [VAL_W-1:0] mat_q [MAT_DEPTH];

	logic adv;
	logic take;
	logic v_s1, v_s2, v_s3;

	logic signed [VAL_W-1:0] rowm_s1 [4][3];
	logic        [32:0]      absp_s1 [6][3];
	logic signed [32:0]      w_s1    [6];
	logic signed [VAL_W-1:0] c_s1    [3];
	logic signed [VAL_W-1:0] e_s1    [3];

	logic signed [63:0] pd_s2 [4][3];
	logic signed [65:0] pr_s2 [6][3];
	logic signed [32:0] w_s2  [6];

	logic signed [65:0] dk_s3 [4];
	logic signed [67:0] rs_s3 [6];
	logic signed [32:0] w_s3  [6];

	logic     out_valid_q;
	verdict_t verdict_q;
	verdict_t verdict_d;

	logic signed [32:0] p_d    [6][4];
	logic        [32:0] absp_d [6][3];

	assign adv       = !out_valid_q || m_tready;
	assign pop_ready = adv;
	assign take      = pop_valid && adv;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {{(OUT_DATA_W-VERDICT_W){1'b0}}, verdict_q};

	// plane components: row3 plus or minus row k
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int s = 0; s < 2; s++) begin
				for (int j = 0; j < 4; j++) begin
					if (s == 0) begin
						p_d[k*2+s][j] = 33'(signed'(mat_q[j*4+3])) + 33'(signed'(mat_q[j*4+k]));
					end else begin
						p_d[k*2+s][j] = 33'(signed'(mat_q[j*4+3])) - 33'(signed'(mat_q[j*4+k]));
					end
				end
				for (int j = 0; j < 3; j++) begin
					absp_d[k*2+s][j] = p_d[k*2+s][j][32] ? 33'(-p_d[k*2+s][j]) : 33'(p_d[k*2+s][j]);
				end
			end
		end
	end

	// verdict from d3 +/- dk against r and scaled w
	always_comb begin
		logic signed [SUM_W-1:0] d;
		logic signed [SUM_W-1:0] r;
		logic signed [SUM_W-1:0] ws;
		logic signed [SUM_W-1:0] t1;
		logic signed [SUM_W-1:0] t2;
		logic outside;
		logic partial;
		outside = 1'b0;
		partial = 1'b0;
		for (int pl = 0; pl < 6; pl++) begin
			if (pl % 2 == 0) begin
				d = SUM_W'(dk_s3[3]) + SUM_W'(dk_s3[pl/2]);
			end else begin
				d = SUM_W'(dk_s3[3]) - SUM_W'(dk_s3[pl/2]);
			end
			r  = SUM_W'(rs_s3[pl]);
			ws = SUM_W'(w_s3[pl]) <<< FRAC_BITS;
			t1 = d + r + ws;
			t2 = d - r + ws;
			if (t1[SUM_W-1]) outside = 1'b1;
			if (t2[SUM_W-1]) partial = 1'b1;
		end
		if (outside)      verdict_d = V_OUTSIDE;
		else if (partial) verdict_d = V_PARTIAL;
		else              verdict_d = V_INSIDE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAT_DEPTH; i++) mat_q[i] <= '0;
		end else if (take && pop_item.op == OP_LOAD) begin
			mat_q[pop_item.entry_index] <= pop_item.entry_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= pop_valid && pop_item.op == OP_TEST;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++)
				for (int j = 0; j < 3; j++)
					rowm_s1[k][j] <= signed'(mat_q[j*4+k]);
			for (int pl = 0; pl < 6; pl++) begin
				for (int j = 0; j < 3; j++) absp_s1[pl][j] <= absp_d[pl][j];
				w_s1[pl] <= p_d[pl][3];
			end
			for (int j = 0; j < 3; j++) begin
				c_s1[j] <= signed'(pop_item.center[j]);
				e_s1[j] <= signed'(pop_item.extent[j]);
			end

			for (int k = 0; k < 4; k++)
				for (int j = 0; j < 3; j++)
					pd_s2[k][j] <= rowm_s1[k][j] * c_s1[j];
			for (int pl = 0; pl < 6; pl++) begin
				for (int j = 0; j < 3; j++)
					pr_s2[pl][j] <= 66'(signed'({1'b0, absp_s1[pl][j]})) * 66'(e_s1[j]);
				w_s2[pl] <= w_s1[pl];
			end

			for (int k = 0; k < 4; k++)
				dk_s3[k] <= 66'(pd_s2[k][0]) + 66'(pd_s2[k][1]) + 66'(pd_s2[k][2]);
			for (int pl = 0; pl < 6; pl++) begin
				rs_s3[pl] <= 68'(pr_s2[pl][0]) + 68'(pr_s2[pl][1]) + 68'(pr_s2[pl][2]);
				w_s3[pl]  <= w_s2[pl];
			end

			verdict_q <= verdict_d;
		end
	end
endmodule

FILE: design/aabb_frustum_cull.sv
`timescale 1ns / 1ps
// aabb_frustum_cull: classifies center/extent boxes against a frustum held as a 4x4 matrix.
// input channel s_*: tuser 0 loads matrix entry entry_index (column*4+row) with
// entry_value, tuser 1 tests the box given by center and half extent.
// output channel m_*: one verdict per test transaction (0 inside, 1 partial,
// 2 outside); load transactions give no result.
// a front register takes each transaction and pushes it into a four-entry queue;
// the back stage pops it, writes loads into the matrix and runs tests through
// a pipeline of plane build, multiply, sum and compare.
// throughput: one transaction per cycle unless m_tready stalls, with parallel multipliers.
// a test passes the front register, the queue, stages s1 to s3 and the verdict register.
// a load affects only tests accepted after it, ordering is kept by the queue.
// reset clears the matrix to zero, empties the queue and drops all results.
// while a verdict waits with m_tready low the back pipeline freezes, the queue
// fills, and s_tready falls once the front register and queue are full.
module aabb_frustum_cull #(
	parameter int FRAC_BITS = afc_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// entry_index[3:0], entry_value[35:4], center_x/y/z[131:36], extent_x/y/z[227:132]
	input  logic [afc_pkg::IN_DATA_W-1:0]  s_tdata,
	// opcode
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// verdict[1:0]
	output logic [afc_pkg::OUT_DATA_W-1:0] m_tdata
);
	import afc_pkg::*;

	logic  push_valid, push_ready, pop_valid, pop_ready;
	item_t push_item, pop_item;

	afc_front u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.push_valid, .push_ready, .push_item
	);

	afc_queue u_queue (
		.clk, .arst_n, .push_valid, .push_ready, .push_item,
		.pop_valid, .pop_ready, .pop_item
	);

	afc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .pop_valid, .pop_ready, .pop_item,
		.m_tvalid, .m_tready, .m_tdata
	);
endmodule

FILE: sim/aabb_frustum_cull_test.sv
`timescale 1ns / 1ps
module aabb_frustum_cull_test;
	import afc_pkg::*;

	class cull_scoreboard;
		logic signed [31:0] mat [16];
		verdict_t verdicts [$];
		int errors;
		int tests;
		int counts [3];

		function void clear();
			foreach (mat[i]) mat[i] = '0;
			verdicts.delete();
			errors = 0;
			tests = 0;
			counts = '{0, 0, 0};
		endfunction

		function verdict_t classify(logic signed [31:0] c [3], logic signed [31:0] e [3]);
			logic signed [32:0] p [4];
			logic signed [33:0] ap;
			logic signed [127:0] d, r, wsc;
			bit outside, partial;
			outside = 0;
			partial = 0;
			for (int k = 0; k < 3; k++) begin
				for (int s = 0; s < 2; s++) begin
					for (int j = 0; j < 4; j++) begin
						if (s == 0) p[j] = 33'(mat[j*4+3]) + 33'(mat[j*4+k]);
						else p[j] = 33'(mat[j*4+3]) - 33'(mat[j*4+k]);
					end
					d = '0;
					r = '0;
					for (int j = 0; j < 3; j++) begin
						// one extra bit so the magnitude of the most negative sum fits
						ap = p[j] < 0 ? -34'(p[j]) : 34'(p[j]);
						d += 128'(p[j]) * 128'(c[j]);
						r += 128'(ap) * 128'(e[j]);
					end
					wsc = 128'(p[3]) <<< 16;
					if (d + r + wsc < 0) outside = 1;
					if (d - r + wsc < 0) partial = 1;
				end
			end
			return outside ? V_OUTSIDE : (partial ? V_PARTIAL : V_INSIDE);
		endfunction

		function void note_input(item_t it);
			logic signed [31:0] c [3], e [3];
			if (it.op == OP_LOAD) begin
				mat[it.entry_index] = it.entry_value;
			end else begin
				for (int j = 0; j < 3; j++) begin
					c[j] = it.center[j];
					e[j] = it.extent[j];
				end
				verdicts.push_back(classify(c, e));
			end
		endfunction

		function void check_result(logic [7:0] data);
			verdict_t exp_v;
			if (verdicts.size() == 0) begin
				$error("verdict with no pending test: actual %0d", data[1:0]);
				errors++;
				return;
			end
			exp_v = verdicts.pop_front();
			tests++;
			if (exp_v <= V_OUTSIDE) counts[exp_v]++;
			if (data[1:0] !== exp_v) begin
				$error("verdict mismatch: expected %0d actual %0d", exp_v, data[1:0]);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	// entry_index, entry_value, center_x/y/z, extent_x/y/z
	logic [IN_DATA_W-1:0] s_tdata;
	// opcode
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	// verdict
	logic [OUT_DATA_W-1:0] m_tdata;

	aabb_frustum_cull dut (.*);

	cull_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	bit recv_hold;
	int cycle_count;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic logic [31:0] rand_val();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
			3: return 32'(int'($urandom_range(0, 2 << 16)) - (1 << 16));
			4: return '0;
			default: return $urandom();
		endcase
	endfunction

	// tvalid stays high after a transaction so the next one can follow at once
	task automatic send_item(item_t it);
		while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.op;
		s_tdata <= IN_DATA_W'({it.extent, it.center, it.entry_value, it.entry_index});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(it);
	endtask

	task automatic stop_input();
		s_tvalid <= 1'b0;
	endtask

	task automatic load_entry(int idx, logic [31:0] v);
		item_t it;
		it = '0;
		it.op = OP_LOAD;
		it.entry_index = MAT_IDX_W'(idx);
		it.entry_value = v;
		send_item(it);
	endtask

	task automatic test_box(logic [31:0] cx, cy, cz, ex, ey, ez);
		item_t it;
		it = '0;
		it.op = OP_TEST;
		it.center = {cz, cy, cx};
		it.extent = {ez, ey, ex};
		send_item(it);
	endtask

	task automatic random_item();
		item_t it;
		it.op = ($urandom_range(0, 99) < 20) ? OP_LOAD : OP_TEST;
		it.entry_index = MAT_IDX_W'($urandom());
		it.entry_value = rand_val();
		for (int j = 0; j < 3; j++) begin
			it.center[j] = rand_val();
			it.extent[j] = rand_val();
		end
		send_item(it);
	endtask

	task automatic load_identity();
		for (int i = 0; i < 16; i++)
			load_entry(i, (i % 5 == 0) ? 32'h0001_0000 : 32'h0);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			m_tready <= !recv_hold && !(recv_idle_pct > 0 &&
				$urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		sb = new();
		sb.clear();
		cycle_count = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		recv_hold = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero matrix gives inside even for extreme boxes
		test_box(32'h8000_0000, 32'h7fff_ffff, 0, 32'h7fff_ffff, 32'h8000_0000, 0);
		load_identity();
		test_box(0, 0, 0, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
		test_box(32'h0000_8000, 0, 0, 32'h0001_0000, 32'h100, 32'h100);
		test_box(32'h0005_0000, 0, 0, 32'h0001_0000, 32'h100, 32'h100);
		// negative extent
		test_box(0, 0, 0, 32'hffff_0000, 32'hffff_0000, 32'hffff_0000);
		test_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		test_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		load_entry(15, 32'h8000_0000);
		load_entry(3, 32'h7fff_ffff);
		test_box(32'h0000_1000, 32'hffff_f000, 0, 32'h10, 32'h10, 32'h10);

		// long receiver hold so the queue fills and input stalls
		recv_hold = 1;
		fork
			repeat (60) random_item();
			begin
				repeat (200) @(posedge clk);
				recv_hold = 0;
			end
		join
		stop_input();
		// pause until all verdicts are back
		while (sb.verdicts.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		load_identity();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 63 : 0;
			recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 35 : 0;
			for (int n = 0; n < 530; n++) begin
				random_item();
				// occasionally restore a sane frustum so verdicts vary
				if ($urandom_range(0, 99) == 0) load_identity();
			end
		end
		stop_input();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (sb.verdicts.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("checked %0d box tests: %0d inside, %0d partial, %0d outside",
			sb.tests, sb.counts[0], sb.counts[1], sb.counts[2]);
		$display("matrix loads, extremes, negative extents and backpressure exercised");
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

FILE: aabb_frustum_cull.f
design/afc_pkg.sv
design/afc_front.sv
design/afc_queue.sv
design/afc_back.sv
design/aabb_frustum_cull.sv
sim/aabb_frustum_cull_test.sv
